### hdl/gedge_pkg.sv
// shared types and constants for the gradient edge threshold block
package gedge_pkg;

	// frame geometry
	localparam int IMAGE_WIDTH  = 128;
	localparam int IMAGE_HEIGHT = 128;
	localparam int COL_W        = $clog2(IMAGE_WIDTH);
	localparam int ROW_W        = $clog2(IMAGE_HEIGHT);

	// payload widths
	localparam int PIX_W   = 8;
	localparam int COORD_W = 7;
	localparam int THR_W   = 9;

	// configuration port
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_EDGE_THRESHOLD = REG_IDX_W'(0);
	localparam logic [THR_W-1:0]     THR_RESET          = THR_W'(64);

	// one line memory entry: the row two above and the row just above
	typedef struct packed {
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] recent;
	} pair_t;

	// line memory access for one cycle
	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] waddr;
		pair_t            wdata;
		logic             re;
		logic [COL_W-1:0] raddr;
	} mem_req_t;

endpackage

### hdl/gedge_ifs.sv
// valid/ready channel interfaces for pixels in and edge results out
interface gedge_pix_if;
	logic                       valid;
	logic                       ready;
	logic [gedge_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface gedge_res_if;
	logic                         valid;
	logic                         ready;
	logic                         edge_res;
	logic [gedge_pkg::COORD_W-1:0] out_row;
	logic [gedge_pkg::COORD_W-1:0] out_column;
	logic                         frame_last;

	modport source (output valid, output edge_res, output out_row, output out_column,
		output frame_last, input ready);
	modport sink (input valid, input edge_res, input out_row, input out_column,
		input frame_last, output ready);
endinterface

### hdl/gradient_edge_threshold_top.sv
// top level of the streaming l1 gradient edge detector
// Pixels enter on the pix channel in raster order, IMAGE_WIDTH per line and
// IMAGE_HEIGHT lines per frame; one pixel is taken per cycle when valid and
// ready are both high. Pixel (r,c) with r >= 1 yields one transaction on the
// res channel for pixel (r-1,c): its edge bit, row, column and a frame_last
// flag on the last result of the frame. The first line yields nothing and
// the bottom line is never reported; border pixels report 0.
// Latency: the result is presented the cycle after its pixel is taken.
// Throughput: one pixel per cycle, set by the single-port write plus one
// read of the line memory per pixel; the read fetches the entry two columns
// ahead so its data is registered by the time the window needs it.
// The output register drains while the next pixel is taken; when the
// receiver stalls with a result pending, pix.ready drops until it is taken.
// Reset (arst_n low) clears the raster position and sets edge_threshold to
// 64; the line memory is not cleared and is refilled by the first frame.
// edge_threshold sits at byte address 0 of the apb port and pready is always
// high; the user must write it only while the block is idle, as the block does not enforce it.
module gradient_edge_threshold_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gedge_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [gedge_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [gedge_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	gedge_pix_if.sink                         pix,
	gedge_res_if.source                       res
);
	import gedge_pkg::*;

	logic [THR_W-1:0] threshold;
	mem_req_t         mem_req;
	pair_t            rd_pair;

	// configuration registers
	gedge_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.threshold (threshold)
	);

	// datapath and control
	gedge_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold),
		.pix       (pix),
		.res       (res),
		.mem_req   (mem_req),
		.rd_pair   (rd_pair)
	);

	// line memory
	gedge_line_mem u_line_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_pair (rd_pair)
	);

endmodule

### hdl/gedge_line_mem.sv
// two-row line memory, one write and one registered read per cycle
module gedge_line_mem (
	input  logic               clk,
	input  gedge_pkg::mem_req_t req,
	output gedge_pkg::pair_t    rd_pair
);
	import gedge_pkg::*;

	pair_t line_mem [IMAGE_WIDTH];
	pair_t rd_pair_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			line_mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_pair_q <= line_mem[req.raddr];
		end
	end

	assign rd_pair = rd_pair_q;

endmodule

### hdl/gedge_cfg.sv
// apb register file holding the edge threshold
module gedge_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [gedge_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [gedge_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [gedge_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready,
	output logic [gedge_pkg::THR_W-1:0]       threshold
);
	import gedge_pkg::*;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [THR_W-1:0]     threshold_q;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	// register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
		end else if (wr_en && reg_idx == REG_EDGE_THRESHOLD) begin
			threshold_q <= pwdata[THR_W-1:0];
		end
	end

	// read decode
	always_comb begin
		unique case (reg_idx)
			REG_EDGE_THRESHOLD: prdata = {{(APB_DATA_W-THR_W){1'b0}}, threshold_q};
			default:            prdata = '0;
		endcase
	end

	assign threshold = threshold_q;

endmodule

### hdl/gedge_core.sv
// raster counters, column window, gradient compare and output register
module gedge_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gedge_pkg::THR_W-1:0] threshold,
	gedge_pix_if.sink                   pix,
	gedge_res_if.source                 res,
	output gedge_pkg::mem_req_t         mem_req,
	input  gedge_pkg::pair_t            rd_pair
);
	import gedge_pkg::*;

	localparam logic [COL_W-1:0] LAST_COL = COL_W'(IMAGE_WIDTH - 1);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(IMAGE_HEIGHT - 1);
	localparam logic [COL_W:0]   WIDTH_X  = (COL_W+1)'(IMAGE_WIDTH);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	pair_t            cur_q;
	logic [PIX_W-1:0] left_q;

	logic             out_valid_q;
	logic             res_edge_q;
	logic [COORD_W-1:0] res_row_q;
	logic [COORD_W-1:0] res_col_q;
	logic             res_last_q;

	logic             accept;
	logic [PIX_W-1:0] diff_h;
	logic [PIX_W-1:0] diff_v;
	logic [THR_W-1:0] grad_sum;
	logic             border;
	logic             emit;
	logic             edge_bit;
	logic [ROW_W-1:0] res_row;
	logic [ROW_W+COORD_W-1:0] row_ext;
	logic [COL_W+COORD_W-1:0] col_ext;
	logic [COL_W:0]   col_plus2;
	logic [COL_W-1:0] ahead_addr;

	// a new pixel is taken whenever the output register is free or draining
	assign pix.ready = !out_valid_q || res.ready;
	assign accept    = pix.valid && pix.ready;

	// gradient about the pixel one row up: left/right from that row, up/down vertical
	always_comb begin
		if (rd_pair.recent >= left_q) begin
			diff_h = rd_pair.recent - left_q;
		end else begin
			diff_h = left_q - rd_pair.recent;
		end
		if (cur_q.older >= pix.pixel) begin
			diff_v = cur_q.older - pix.pixel;
		end else begin
			diff_v = pix.pixel - cur_q.older;
		end
		grad_sum = {1'b0, diff_h} + {1'b0, diff_v};
	end

	// top row and both side columns never mark an edge
	assign border   = (row_q == ROW_W'(1)) || (col_q == '0) || (col_q == LAST_COL);
	assign emit     = (row_q != '0);
	assign edge_bit = !border && (grad_sum >= threshold);
	assign res_row  = row_q - ROW_W'(1);
	assign row_ext  = {{COORD_W{1'b0}}, res_row};
	assign col_ext  = {{COORD_W{1'b0}}, col_q};

	// entry two columns ahead, wrapping into the next row
	always_comb begin
		col_plus2 = {1'b0, col_q} + (COL_W+1)'(2);
		if (col_plus2 >= WIDTH_X) begin
			ahead_addr = COL_W'(col_plus2 - WIDTH_X);
		end else begin
			ahead_addr = col_plus2[COL_W-1:0];
		end
	end

	// shift the column into the older row, prefetch the window's right side
	always_comb begin
		mem_req.we           = accept;
		mem_req.waddr        = col_q;
		mem_req.wdata.older  = cur_q.recent;
		mem_req.wdata.recent = pix.pixel;
		mem_req.re           = accept;
		mem_req.raddr        = ahead_addr;
	end

	// raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_q == LAST_COL) begin
				col_q <= '0;
				row_q <= (row_q == LAST_ROW) ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// column window: current entry and the left neighbor of the row above
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= rd_pair;
			left_q <= cur_q.recent;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_edge_q <= edge_bit;
			res_row_q  <= row_ext[COORD_W-1:0];
			res_col_q  <= col_ext[COORD_W-1:0];
			res_last_q <= (row_q == LAST_ROW) && (col_q == LAST_COL);
		end
	end

	assign res.valid      = out_valid_q;
	assign res.edge_res   = res_edge_q;
	assign res.out_row    = res_row_q;
	assign res.out_column = res_col_q;
	assign res.frame_last = res_last_q;

	// prefetch never targets the entry being written
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we && mem_req.re |-> mem_req.raddr != mem_req.waddr)
		else $error("line memory read and write hit the same entry");

	// the first row of a frame produces no transaction
	a_row0_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && row_q == '0 |=> !out_valid_q)
		else $error("result produced for the first row");

	// column wraps after the last pixel of a line
	a_col_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && col_q == LAST_COL |=> col_q == '0)
		else $error("column counter did not wrap");

	// end of frame only flagged on a right border pixel, which is never an edge
	a_last_border: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_last_q |-> !res_edge_q)
		else $error("frame end flagged on an edge pixel");

endmodule

### verif/gedge_edge_checker.sv
// checker for the gradient edge block: tracks the raster, predicts edge bits, compares results
module gedge_edge_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	gedge_pix_if                             pix,
	gedge_res_if                             res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic                             pready,
	input  logic [gedge_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [gedge_pkg::APB_DATA_W-1:0] pwdata,
	output int                               mismatches,
	output int                               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import gedge_pkg::*;

	typedef struct packed {
		logic               edge_res;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] column;
		logic               frame_last;
	} edge_result_t;

	// edge bits still owed by the block, oldest first
	edge_result_t     expected_edges[$];

	// own copy of the line stores, raster position and threshold
	logic [PIX_W-1:0] line_two_up [IMAGE_WIDTH];
	logic [PIX_W-1:0] line_one_up [IMAGE_WIDTH];
	int               next_row;
	int               next_col;
	logic [THR_W-1:0] threshold;
	int               results_seen;

	function automatic int unsigned pixel_gap(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// one accepted pixel: queue the edge bit of the pixel above, then shift the line stores
	function automatic void track_pixel(input logic [PIX_W-1:0] px);
		int           centre_row;
		logic         border;
		int unsigned  grad_sum;
		edge_result_t want;
		if (next_row >= 1) begin
			centre_row = next_row - 1;
			border = (centre_row == 0) || (next_col == 0) || (next_col == IMAGE_WIDTH - 1) ||
				(centre_row == IMAGE_HEIGHT - 1);
			want.edge_res = 1'b0;
			if (!border) begin
				// left neighbour was already shifted into the older store
				grad_sum = pixel_gap(line_one_up[next_col + 1], line_two_up[next_col - 1]) +
					pixel_gap(line_two_up[next_col], px);
				want.edge_res = (grad_sum >= threshold);
			end
			want.row        = COORD_W'(centre_row);
			want.column     = COORD_W'(next_col);
			want.frame_last = (centre_row == IMAGE_HEIGHT - 2) && (next_col == IMAGE_WIDTH - 1);
			expected_edges.push_back(want);
		end
		line_two_up[next_col] = line_one_up[next_col];
		line_one_up[next_col] = px;
		// raster advance with frame wrap
		if (next_col == IMAGE_WIDTH - 1) begin
			next_col = 0;
			next_row = (next_row == IMAGE_HEIGHT - 1) ? 0 : next_row + 1;
		end else begin
			next_col = next_col + 1;
		end
	endfunction

	// one accepted result transaction against the oldest expectation
	function automatic void check_result();
		edge_result_t got;
		edge_result_t want;
		got = '{res.edge_res, res.out_row, res.out_column, res.frame_last};
		results_seen++;
		if (expected_edges.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d with nothing expected: edge %0b row %0d col %0d last %0b",
					results_seen, got.edge_res, got.row, got.column, got.frame_last);
			return;
		end
		want = expected_edges.pop_front();
		if (got.edge_res != want.edge_res || got.row != want.row ||
				got.column != want.column || got.frame_last != want.frame_last) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d mismatch: expected edge %0b row %0d col %0d last %0b, %s",
					results_seen, want.edge_res, want.row, want.column, want.frame_last,
					$sformatf("got edge %0b row %0d col %0d last %0b (threshold %0d)",
						got.edge_res, got.row, got.column, got.frame_last, threshold));
		end
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_edges.delete();
			next_row     = 0;
			next_col     = 0;
			threshold    = THR_RESET;
			mismatches   = 0;
			results_seen = 0;
			pending     <= 0;
		end else begin
			if (res.valid && res.ready)
				check_result();
			if (pix.valid && pix.ready)
				track_pixel(pix.pixel);
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_EDGE_THRESHOLD)
				threshold = pwdata[THR_W-1:0];
			pending <= expected_edges.size();
		end
	end

endmodule

### verif/gradient_edge_threshold_top_test.sv
// testbench top: clock, reset, pixel and register stimulus, result back-pressure and verdict
module gradient_edge_threshold_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import gedge_pkg::*;

	localparam int FRAME_PIXELS  = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int REG_SPARE     = 1;
	localparam int THR_MAX       = 2 ** THR_W - 1;
	localparam int LATENCY_SLACK = 4;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 300;
	localparam int CYCLE_LIMIT   = 2000000;
	localparam int NUM_PHASES    = 5;

	typedef enum int {STYLE_NOISE, STYLE_EXTREME, STYLE_SMOOTH, STYLE_CHECKER} row_style_e;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	gedge_pix_if pix ();
	gedge_res_if res ();

	int         mismatch_count;
	int         pending_results;
	int         sent;
	int         taken;
	int         cycles;
	int         stall_left;
	logic       hold_off = 1'b0;
	logic       calm;
	row_style_e row_style;
	int         row_base;

	// phase boundaries in pixels; the first one reaches the interior of the fourth row
	int         phase_end [NUM_PHASES] = '{400, 500, 600, 700, 800};
	logic [PIX_W-1:0] opening_pixels [20] = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08,
		8'h10, 8'h20, 8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
		8'h55, 8'hAA};

	gradient_edge_threshold_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix),
		.res     (res)
	);

	gedge_edge_checker edge_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.pix        (pix),
		.res        (res),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatch_count),
		.pending    (pending_results)
	);

	always #10 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side back-pressure: random stall bursts, one long hold-off, none in the tail
	always @(posedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_off) begin
			res.ready <= 1'b0;
		end else if (stall_left != 0) begin
			res.ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			res.ready  <= 1'b0;
			stall_left <= $urandom_range(0, 13);
		end else begin
			res.ready <= 1'b1;
		end
	end

	// long receiver hold-off so the block fills and stalls the pixel channel
	initial begin
		while (taken < HOLD_AT)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// pixel content: opening extremes, then a random style per row
	function automatic logic [PIX_W-1:0] pick_pixel(input int k);
		int pos;
		int row;
		int col;
		pos = k % FRAME_PIXELS;
		row = pos / IMAGE_WIDTH;
		col = pos % IMAGE_WIDTH;
		if (k < $size(opening_pixels))
			return opening_pixels[k];
		if (col == 0) begin
			row_style = row_style_e'($urandom_range(0, 3));
			row_base  = $urandom_range(0, 248);
		end
		case (row_style)
			STYLE_NOISE:   return PIX_W'($urandom_range(0, 255));
			STYLE_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			STYLE_SMOOTH:  return PIX_W'(row_base + $urandom_range(0, 7));
			default:       return ((row + col) % 2 != 0) ? 8'hFF : 8'h00;
		endcase
	endfunction

	// pixel transactions up to a count, with random idle bursts
	task automatic send_pixels(input int upto);
		while (sent < upto) begin
			if (!calm && $urandom_range(0, 4) == 0) begin
				pix.valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			pix.valid <= 1'b1;
			pix.pixel <= pick_pixel(sent);
			do @(posedge clk); while (!pix.ready);
			sent++;
			taken <= sent;
		end
	endtask

	// let every owed result drain before touching the register
	task automatic wait_idle();
		pix.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (LATENCY_SLACK) @(posedge clk);
	endtask

	// apb write: setup then access cycle
	task automatic cfg_write(input int index, input logic [APB_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_ADDR_W'(index * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		pix.valid  = 1'b0;
		pix.pixel  = '0;
		calm       = 1'b0;
		sent       = 0;
		taken      = 0;
		row_style  = STYLE_NOISE;
		row_base   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// phases of threshold settings, first one on the reset value
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			if (phase > 0) begin
				wait_idle();
				case (phase)
					1:       cfg_write(REG_EDGE_THRESHOLD, 0);
					2:       cfg_write(REG_EDGE_THRESHOLD, THR_MAX);
					3:       cfg_write(REG_EDGE_THRESHOLD, $urandom_range(1, THR_MAX - 1));
					default: cfg_write(REG_EDGE_THRESHOLD, $urandom_range(0, THR_MAX));
				endcase
				// unmapped register index must leave the threshold alone
				if (phase == 2) begin
					@(posedge clk);
					cfg_write(REG_SPARE, $urandom);
				end
				@(posedge clk);
			end
			if (phase == NUM_PHASES - 1)
				calm <= 1'b1;
			send_pixels(phase_end[phase]);
		end

		// drain and verdict
		wait_idle();
		repeat (LATENCY_SLACK) @(posedge clk);
		if (mismatch_count == 0 && pending_results == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
